>>> rtl/assert_macros.svh
// assertion macros for the camera ray generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/crg_pkg.sv
// types, constants and helpers for the camera ray generator
package crg_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int REG_W       = 23;
	localparam int QUAT_W      = 18;
	localparam int RAY_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int PROD_W      = 2 * QUAT_W;
	localparam int MAT_W       = PROD_W + 2;
	localparam int TERM_W      = MAT_W + RAY_W;
	localparam int ACC_W       = TERM_W + 2;
	localparam int ROUND_SHIFT = 2 * FRAC_BITS;
	localparam int SCALE_W     = REG_W + COORD_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_STEP    = 3'd0,
		CFG_X_HALF_EXTENT = 3'd1,
		CFG_Y_HALF_EXTENT = 3'd2,
		CFG_QUAT_W        = 3'd3,
		CFG_QUAT_X        = 3'd4,
		CFG_QUAT_Y        = 3'd5,
		CFG_QUAT_Z        = 3'd6
	} cfg_idx_t;

	typedef logic signed [QUAT_W-1:0] quat_part_t;
	typedef logic signed [MAT_W-1:0]  mat_entry_t;
	typedef logic signed [RAY_W-1:0]  ray_t;

	typedef struct packed {
		quat_part_t w;
		quat_part_t x;
		quat_part_t y;
		quat_part_t z;
	} quat_t;

	typedef struct packed {
		mat_entry_t m00;
		mat_entry_t m01;
		mat_entry_t m02;
		mat_entry_t m10;
		mat_entry_t m11;
		mat_entry_t m12;
		mat_entry_t m20;
		mat_entry_t m21;
		mat_entry_t m22;
	} rot_mat_t;

	localparam logic [REG_W-1:0] STEP_RST   = REG_W'(256);
	localparam logic [REG_W-1:0] EXTENT_RST = REG_W'(1) << FRAC_BITS;
	localparam quat_part_t       QUAT_ONE   = QUAT_W'(1) << FRAC_BITS;
	localparam logic signed [PROD_W-1:0] PROD_ONE = PROD_W'(1) << ROUND_SHIFT;

	localparam ray_t RAY_MAX = {1'b0, {(RAY_W-1){1'b1}}};
	localparam ray_t RAY_MIN = {1'b1, {(RAY_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_RAY_MAX = ACC_W'(RAY_MAX);
	localparam logic signed [ACC_W-1:0] ACC_RAY_MIN = ACC_W'(RAY_MIN);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS  = ACC_W'(1) << (ROUND_SHIFT - 1);

	function automatic ray_t sat_ray(input logic signed [ACC_W-1:0] v);
		ray_t r;
		if (v > ACC_RAY_MAX) begin
			r = RAY_MAX;
		end else if (v < ACC_RAY_MIN) begin
			r = RAY_MIN;
		end else begin
			r = $signed(v[RAY_W-1:0]);
		end
		return r;
	endfunction

endpackage

>>> rtl/crg_matrix.sv
// quaternion to rotation matrix, two register stages
module crg_matrix import crg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  quat_t    quat,
	output rot_mat_t rot
);

	logic signed [PROD_W-1:0] ww_q, xx_q, yy_q, zz_q;
	logic signed [PROD_W-1:0] xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
	rot_mat_t rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= PROD_ONE;
			xx_q <= '0;
			yy_q <= '0;
			zz_q <= '0;
			xy_q <= '0;
			wz_q <= '0;
			xz_q <= '0;
			wy_q <= '0;
			yz_q <= '0;
			wx_q <= '0;
		end else begin
			ww_q <= quat.w * quat.w;
			xx_q <= quat.x * quat.x;
			yy_q <= quat.y * quat.y;
			zz_q <= quat.z * quat.z;
			xy_q <= quat.x * quat.y;
			wz_q <= quat.w * quat.z;
			xz_q <= quat.x * quat.z;
			wy_q <= quat.w * quat.y;
			yz_q <= quat.y * quat.z;
			wx_q <= quat.w * quat.x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.m00 <= MAT_W'(PROD_ONE);
			rot_q.m01 <= '0;
			rot_q.m02 <= '0;
			rot_q.m10 <= '0;
			rot_q.m11 <= MAT_W'(PROD_ONE);
			rot_q.m12 <= '0;
			rot_q.m20 <= '0;
			rot_q.m21 <= '0;
			rot_q.m22 <= MAT_W'(PROD_ONE);
		end else begin
			rot_q.m00 <= MAT_W'(ww_q) + MAT_W'(xx_q) - MAT_W'(yy_q) - MAT_W'(zz_q);
			rot_q.m11 <= MAT_W'(ww_q) - MAT_W'(xx_q) + MAT_W'(yy_q) - MAT_W'(zz_q);
			rot_q.m22 <= MAT_W'(ww_q) - MAT_W'(xx_q) - MAT_W'(yy_q) + MAT_W'(zz_q);
			rot_q.m01 <= (MAT_W'(xy_q) - MAT_W'(wz_q)) <<< 1;
			rot_q.m10 <= (MAT_W'(xy_q) + MAT_W'(wz_q)) <<< 1;
			rot_q.m02 <= (MAT_W'(xz_q) + MAT_W'(wy_q)) <<< 1;
			rot_q.m20 <= (MAT_W'(xz_q) - MAT_W'(wy_q)) <<< 1;
			rot_q.m12 <= (MAT_W'(yz_q) - MAT_W'(wx_q)) <<< 1;
			rot_q.m21 <= (MAT_W'(yz_q) + MAT_W'(wx_q)) <<< 1;
		end
	end

	assign rot = rot_q;

endmodule

>>> rtl/camera_ray_generator.sv
// camera ray generator top level: config registers and the five-stage ray pipeline
//
// pixel beats (pixel_x, pixel_y) enter on in_valid/in_ready; each one yields
// exactly one world-space ray beat (ray_x, ray_y, ray_z) on out_valid/out_ready,
// in order. the pipeline has five register stages: pixel capture, view-plane
// vector, rotation products, sums with rounding bias, round/saturate output.
// one beat per cycle is sustained while out_ready is high and cfg_valid is low.
// each stage holds while the stage after it is full and stalled, so when the
// receiver drops out_ready the bubbles close up first and in_ready falls only
// once all five stages are full. nothing is dropped or repeated.
// config beats (cfg_index, cfg_data) are always taken; in_ready is low in a
// cycle with cfg_valid high. the quaternion feeds a two-stage matrix unit whose
// output is ready before a pixel taken after the write reaches the products.
// reset (arst_n low) empties the pipeline and loads step 256, half extents 1.0
// and the identity quaternion.
module camera_ray_generator import crg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ray_t                  ray_x,
	output ray_t                  ray_y,
	output ray_t                  ray_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]      cfg_data
);

`include "assert_macros.svh"

	logic [REG_W-1:0] pixel_step_q, x_half_extent_q, y_half_extent_q;
	quat_t            quat_q;
	rot_mat_t         rot;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic in_fire;

	logic [COORD_BITS-1:0] px_s1, py_s1;
	ray_t vx_s2, vz_s2;
	logic signed [TERM_W-1:0] t_s3 [3][3];
	logic signed [ACC_W-1:0]  acc_s4 [3];
	ray_t ray_s5 [3];

	logic [SCALE_W-1:0]      sx, sz;
	logic signed [ACC_W-1:0] vx_wide, vz_wide;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_step_q    <= STEP_RST;
			x_half_extent_q <= EXTENT_RST;
			y_half_extent_q <= EXTENT_RST;
			quat_q.w        <= QUAT_ONE;
			quat_q.x        <= '0;
			quat_q.y        <= '0;
			quat_q.z        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PIXEL_STEP:    pixel_step_q    <= cfg_data;
				CFG_X_HALF_EXTENT: x_half_extent_q <= cfg_data;
				CFG_Y_HALF_EXTENT: y_half_extent_q <= cfg_data;
				CFG_QUAT_W:        quat_q.w        <= cfg_data[QUAT_W-1:0];
				CFG_QUAT_X:        quat_q.x        <= cfg_data[QUAT_W-1:0];
				CFG_QUAT_Y:        quat_q.y        <= cfg_data[QUAT_W-1:0];
				CFG_QUAT_Z:        quat_q.z        <= cfg_data[QUAT_W-1:0];
				default: ;
			endcase
		end
	end

	crg_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.quat   (quat_q),
		.rot    (rot)
	);

	// stage enables, bubbles collapse
	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1 && !cfg_valid;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_fire;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// view-plane vector
	always_comb begin
		sx      = pixel_step_q * px_s1;
		sz      = pixel_step_q * py_s1;
		vx_wide = ACC_W'(sx) - ACC_W'(x_half_extent_q);
		vz_wide = ACC_W'(y_half_extent_q) - ACC_W'(sz);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
		if (en_s2 && valid_s1) begin
			vx_s2 <= sat_ray(vx_wide);
			vz_s2 <= sat_ray(vz_wide);
		end
		if (en_s3 && valid_s2) begin
			// middle component is exactly one, a shift
			t_s3[0][0] <= rot.m00 * vx_s2;
			t_s3[0][1] <= TERM_W'(rot.m01) <<< FRAC_BITS;
			t_s3[0][2] <= rot.m02 * vz_s2;
			t_s3[1][0] <= rot.m10 * vx_s2;
			t_s3[1][1] <= TERM_W'(rot.m11) <<< FRAC_BITS;
			t_s3[1][2] <= rot.m12 * vz_s2;
			t_s3[2][0] <= rot.m20 * vx_s2;
			t_s3[2][1] <= TERM_W'(rot.m21) <<< FRAC_BITS;
			t_s3[2][2] <= rot.m22 * vz_s2;
		end
		if (en_s4 && valid_s3) begin
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= ACC_W'(t_s3[i][0]) + ACC_W'(t_s3[i][1])
					+ ACC_W'(t_s3[i][2]) + ROUND_BIAS;
			end
		end
		if (en_s5 && valid_s4) begin
			for (int i = 0; i < 3; i++) begin
				ray_s5[i] <= sat_ray(acc_s4[i] >>> ROUND_SHIFT);
			end
		end
	end

	assign out_valid = valid_s5;
	assign ray_x     = ray_s5[0];
	assign ray_y     = ray_s5[1];
	assign ray_z     = ray_s5[2];

	`ASSERT_PROP(a_fire_loads_s1, clk, arst_n, in_fire |=> valid_s1 && px_s1 == $past(pixel_x))
	`ASSERT_PROP(a_s2_holds, clk, arst_n, valid_s2 && !en_s3 |=> valid_s2 && $stable(vx_s2))
	`ASSERT_PROP(a_s4_to_out, clk, arst_n, valid_s4 && en_s5 |=> out_valid)
	`ASSERT_NEVER(a_no_cfg_with_pixel, clk, arst_n, in_fire && cfg_valid)

endmodule
